[sv/rotary_pulse_dial_decoder_assert.svh]
// Assertion macros used by the checker file.
`ifndef ROTARY_PULSE_DIAL_DECODER_ASSERT_SVH
`define ROTARY_PULSE_DIAL_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RPDD_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RPDD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[sv/rpdd_pkg.sv]
package rpdd_pkg;

   // Widths of the fixed fields
   localparam int unsigned CSR_BITS       = 32;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned PULSE_BITS     = 4;
   localparam int unsigned DIGIT_BITS     = 4;

   localparam int unsigned TIME_BITS_DEFAULT = 32;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_PULSE_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIGIT_GAP          = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUMBER_TIMEOUT     = 2'd2;

   // Register reset values
   localparam logic [CSR_BITS-1:0] MIN_PULSE_INTERVAL_RESET = 32'd7000;
   localparam logic [CSR_BITS-1:0] DIGIT_GAP_RESET          = 32'd300000;
   localparam logic [CSR_BITS-1:0] NUMBER_TIMEOUT_RESET     = 32'd10000000;

   // Command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   // Pulse count limits
   localparam logic [PULSE_BITS-1:0] COUNT_MAX  = 4'd15;
   localparam logic [PULSE_BITS-1:0] TEN_PULSES = 4'd10;
   localparam logic [DIGIT_BITS-1:0] DIGIT_ZERO = 4'd0;

   typedef struct packed {
      logic command;
      logic line_level;
   } req_type;

   typedef struct packed {
      logic                  digit_valid;
      logic [DIGIT_BITS-1:0] digit_value;
      logic                  session_done;
      logic                  success;
      logic                  pulse_error;
   } rsp_type;

   typedef struct packed {
      logic [CSR_BITS-1:0] min_pulse_interval;
      logic [CSR_BITS-1:0] digit_gap;
      logic [CSR_BITS-1:0] number_timeout;
   } cfg_type;

endpackage

[sv/rotary_pulse_dial_decoder.sv]
// Rotary pulse dial decoder.
// Request channel (req_valid/req_ready/req_payload): one beat per sample tick
// or start command. A start command opens a number session; every tick beat
// carries the sampled line level, one beat per microsecond of line time.
// Response channel (rsp_valid/rsp_ready/rsp_payload): one beat per decoded
// digit or session end; most tick beats give no response.
// Configuration (csr_write_en/csr_index/csr_wdata): write while idle only.
// A beat that causes a response passes from the input register through the
// step logic into the output register, which presents the response.
// Throughput: one beat per cycle while no response stalls; the step logic updates the session state per beat.
// A stalled response holds in the output register; the input register keeps
// taking beats until it is also full, then req_ready drops.
// Reset: registers return to their defaults, no session is open, the line
// is taken as high and both pipeline registers empty.
module rotary_pulse_dial_decoder #(
   parameter int unsigned TIME_BITS = rpdd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rpdd_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rpdd_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_write_en,
   input  logic [rpdd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rpdd_pkg::CSR_BITS-1:0]       csr_wdata
);
   import rpdd_pkg::*;

   cfg_type cfg;
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    advance;
   logic    step_valid;
   rsp_type step_rsp;

   rpdd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   rpdd_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (advance),
      .item         (in_data_ff),
      .cfg          (cfg),
      .result_valid (step_valid),
      .result       (step_rsp)
   );

   // Advance the held beat when the output register can take a result
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && step_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (advance && step_valid) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

[sv/rpdd_csr.sv]
module rpdd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [rpdd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rpdd_pkg::CSR_BITS-1:0]        csr_wdata,
   output rpdd_pkg::cfg_type                    cfg
);
   import rpdd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MIN_PULSE_INTERVAL: cfg_in.min_pulse_interval = csr_wdata;
            CSR_DIGIT_GAP:          cfg_in.digit_gap          = csr_wdata;
            CSR_NUMBER_TIMEOUT:     cfg_in.number_timeout     = csr_wdata;
            default:                cfg_in                    = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse_interval <= MIN_PULSE_INTERVAL_RESET;
         cfg_ff.digit_gap          <= DIGIT_GAP_RESET;
         cfg_ff.number_timeout     <= NUMBER_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/rpdd_core.sv]
module rpdd_core #(
   parameter int unsigned TIME_BITS = rpdd_pkg::TIME_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  rpdd_pkg::req_type item,
   input  rpdd_pkg::cfg_type cfg,
   output logic              result_valid,
   output rpdd_pkg::rsp_type result
);
   import rpdd_pkg::*;

   localparam int unsigned CMP_BITS = (TIME_BITS > CSR_BITS) ? TIME_BITS : CSR_BITS;

   // Session state
   logic                  active_ff, active_in;
   logic                  prev_ff, prev_in;
   logic [PULSE_BITS-1:0] count_ff, count_in;
   logic                  seen_ff, seen_in;
   logic [TIME_BITS-1:0]  tsf_ff, tsf_in;
   logic [TIME_BITS-1:0]  sess_ff, sess_in;
   logic                  any_ff, any_in;

   logic [TIME_BITS-1:0] tsf_inc;
   logic [TIME_BITS-1:0] sess_inc;
   logic [CMP_BITS-1:0]  min_ext;
   logic [CMP_BITS-1:0]  gap_ext;
   logic [CMP_BITS-1:0]  timeout_ext;
   logic                 fall;
   logic                 timed_out;

   // Saturating tick counters
   assign tsf_inc  = (tsf_ff == '1) ? tsf_ff : tsf_ff + TIME_BITS'(1);
   assign sess_inc = (sess_ff == '1) ? sess_ff : sess_ff + TIME_BITS'(1);

   assign min_ext     = CMP_BITS'(cfg.min_pulse_interval);
   assign gap_ext     = CMP_BITS'(cfg.digit_gap);
   assign timeout_ext = CMP_BITS'(cfg.number_timeout);

   assign fall      = prev_ff & ~item.line_level;
   assign timed_out = CMP_BITS'(sess_ff) >= timeout_ext;

   // Step the session for one beat
   always_comb begin
      active_in    = active_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      tsf_in       = tsf_ff;
      sess_in      = sess_ff;
      any_in       = any_ff;
      result_valid = 1'b0;
      result       = '0;

      if (fire) begin
         if (item.command == CMD_START) begin
            // Open a fresh session, dropping any open one; a zero timeout ends it at once
            prev_in  = item.line_level;
            count_in = '0;
            seen_in  = 1'b0;
            tsf_in   = '0;
            sess_in  = '0;
            any_in   = 1'b0;
            if (cfg.number_timeout == '0) begin
               active_in           = 1'b0;
               result_valid        = 1'b1;
               result.session_done = 1'b1;
            end else begin
               active_in = 1'b1;
            end
         end else if (!active_ff) begin
            prev_in = item.line_level;
         end else if (timed_out) begin
            // Timeout already passed: end without sampling
            active_in           = 1'b0;
            prev_in             = item.line_level;
            result_valid        = 1'b1;
            result.session_done = 1'b1;
            result.success      = any_ff;
         end else begin
            if (seen_ff) begin
               tsf_in = tsf_inc;
            end
            prev_in = item.line_level;

            // Count a qualified falling edge
            if (fall && (!seen_ff || CMP_BITS'(tsf_in) >= min_ext)) begin
               count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + PULSE_BITS'(1);
               seen_in  = 1'b1;
               tsf_in   = '0;
            end

            if (count_in != '0 && CMP_BITS'(tsf_in) > gap_ext && count_in > TEN_PULSES) begin
               // Too many pulses: end with error
               active_in           = 1'b0;
               result_valid        = 1'b1;
               result.session_done = 1'b1;
               result.success      = any_ff;
               result.pulse_error  = 1'b1;
            end else begin
               if (count_in != '0 && CMP_BITS'(tsf_in) > gap_ext) begin
                  // Digit complete
                  result_valid       = 1'b1;
                  result.digit_valid = 1'b1;
                  result.digit_value = (count_in == TEN_PULSES) ? DIGIT_ZERO
                                                                : DIGIT_BITS'(count_in);
                  any_in             = 1'b1;
                  count_in           = '0;
                  seen_in            = 1'b0;
                  tsf_in             = '0;
               end

               sess_in = sess_inc;
               if (CMP_BITS'(sess_inc) >= timeout_ext) begin
                  active_in           = 1'b0;
                  result_valid        = 1'b1;
                  result.session_done = 1'b1;
                  result.success      = any_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         prev_ff   <= 1'b1;
         count_ff  <= '0;
         seen_ff   <= 1'b0;
         tsf_ff    <= '0;
         sess_ff   <= '0;
         any_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         prev_ff   <= prev_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
         tsf_ff    <= tsf_in;
         sess_ff   <= sess_in;
         any_ff    <= any_in;
      end
   end

endmodule

[sv/rpdd_checker.sv]
`include "rotary_pulse_dial_decoder_assert.svh"

module rpdd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rpdd_pkg::rsp_type rsp_payload
);
   import rpdd_pkg::*;

   // Hold a stalled response beat
   `RPDD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response beat changed while stalled")

   // Every response beat reports a digit or a session end
   `RPDD_ASSERT_NOW(a_rsp_nonempty, clock, reset, rsp_valid, rsp_payload.digit_valid || rsp_payload.session_done, "empty response beat")

   // Digits stay in range
   `RPDD_ASSERT_NOW(a_digit_range, clock, reset, rsp_valid && rsp_payload.digit_valid, rsp_payload.digit_value <= 4'd9, "digit out of range")

   // Success and error only come with a session end
   `RPDD_ASSERT_NOW(a_end_flags, clock, reset, rsp_valid && !rsp_payload.session_done, !rsp_payload.success && !rsp_payload.pulse_error, "end flags without session end")

   // A pulse error carries no digit
   `RPDD_ASSERT_NOW(a_error_no_digit, clock, reset, rsp_valid && rsp_payload.pulse_error, !rsp_payload.digit_valid && rsp_payload.digit_value == DIGIT_ZERO, "digit reported with pulse error")

endmodule

bind rotary_pulse_dial_decoder rpdd_checker u_rpdd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
